// ===== src/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// shared types, constants and helpers of the risc instruction step core
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int MEM_WORDS = 1024;
   localparam int ADDR_W    = $clog2(MEM_WORDS);
   localparam int PC_W      = ADDR_W + 2;
   localparam int DATA_W    = 32;
   localparam int NUM_REGS  = 16;
   localparam int REG_W     = $clog2(NUM_REGS);
   localparam int OUT_PC_W  = 12;
   localparam logic [REG_W-1:0] LINK_REG = REG_W'(NUM_REGS - 1);

   typedef struct packed {
      logic        cmd;
      logic [11:0] load_address;
      logic [31:0] load_word;
   } req_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_DIV_ZERO = 2'd1,
      STAT_UNDEF    = 2'd2
   } status_type;

   typedef struct packed {
      logic [OUT_PC_W-1:0] exec_pc;
      logic [OUT_PC_W-1:0] next_pc;
      logic                reg_written;
      logic [3:0]          dest_reg;
      logic [31:0]         write_value;
      logic                flag_eq;
      logic                flag_gt;
      status_type          status;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
      OP_MOD  = 5'd4,  OP_CMP  = 5'd5,  OP_AND  = 5'd6,  OP_OR   = 5'd7,
      OP_NOT  = 5'd8,  OP_MOV  = 5'd9,  OP_LSL  = 5'd10, OP_LSR  = 5'd11,
      OP_ASR  = 5'd12, OP_NOP  = 5'd13, OP_LD   = 5'd14, OP_ST   = 5'd15,
      OP_BEQ  = 5'd16, OP_BGT  = 5'd17, OP_B    = 5'd18, OP_CALL = 5'd19,
      OP_RET  = 5'd20
   } op_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOAD, S_FETCH, S_DECODE, S_READ,
      S_OPER, S_EXEC, S_DIV, S_MEM, S_WB
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic mem_clear;
      logic accept;
      logic load_wr;
      logic fetch;
      logic ir_load;
      logic ops_load;
      logic read_third;
      logic exec;
      logic mem_capture;
      logic commit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic is_div;
      logic is_ld;
      logic div_done;
   } dp_sts_type;

   function automatic logic [ADDR_W-1:0] word_index(input logic [31:0] addr);
      return addr[ADDR_W+1:2];
   endfunction

endpackage

// ===== src/rsc_div.sv =====
// ----------------------------------------------------------------------------
// rsc_div
// signed 32-bit divide / modulo, one restoring step per cycle
// ----------------------------------------------------------------------------
module rsc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        want_rem,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        na_ff, na_in;
   logic        nb_ff, nb_in;
   logic        rem_sel_ff, rem_sel_in;
   logic [32:0] trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dvs_in     = dvs_ff;
      na_in      = na_ff;
      nb_in      = nb_ff;
      rem_sel_in = rem_sel_ff;
      trial      = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         na_in      = dividend[31];
         nb_in      = divisor[31];
         quo_in     = dividend[31] ? (32'd0 - dividend) : dividend;
         dvs_in     = divisor[31] ? (32'd0 - divisor) : divisor;
         rem_sel_in = want_rem;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dvs_ff     <= dvs_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      rem_sel_ff <= rem_sel_in;
   end

   assign done = done_ff;
   always_comb begin
      if (rem_sel_ff) result = na_ff ? (32'd0 - rem_ff) : rem_ff;
      else            result = (na_ff ^ nb_ff) ? (32'd0 - quo_ff) : quo_ff;
   end

endmodule

// ===== src/rsc_dp.sv =====
// ----------------------------------------------------------------------------
// rsc_dp
// datapath: word memory, register file, alu, divider and result register
// ----------------------------------------------------------------------------
module rsc_dp (
   input  logic                clock,
   input  logic                reset,
   input  rsc_pkg::req_type    req_payload,
   input  rsc_pkg::dp_cmd_type cmd,
   output rsc_pkg::dp_sts_type sts,
   output rsc_pkg::rsp_type    rsp_payload
);

   localparam int AW = rsc_pkg::ADDR_W;
   localparam int PW = rsc_pkg::PC_W;
   localparam int RW = rsc_pkg::REG_W;

   rsc_pkg::req_type    req_ff;
   logic [AW-1:0]       clr_cnt_ff;
   logic [PW-1:0]       pc_ff;
   logic                eq_ff, gt_ff;
   logic [31:0]         ir_ff;
   logic [31:0]         a_ff, rs2v_ff;
   logic [31:0]         mem [rsc_pkg::MEM_WORDS];
   logic [31:0]         mem_q_ff;
   logic [31:0]         rf_mem [rsc_pkg::NUM_REGS];
   logic [rsc_pkg::NUM_REGS-1:0] rf_vld_ff;
   logic [31:0]         rfa_q_ff, rfb_q_ff;
   logic [31:0]         val_ff, val_in;
   logic                wr_ff, wr_in;
   logic [RW-1:0]       rd_ff, rd_in;
   logic [PW-1:0]       npc_ff, npc_in;
   rsc_pkg::status_type stat_ff, stat_in;
   logic                neq_ff, neq_in, ngt_ff, ngt_in;
   rsc_pkg::rsp_type    rsp_ff;

   rsc_pkg::op_type     op;
   logic [RW-1:0]       rdi, rs1, rs2, ra, rb;
   logic [31:0]         imm, b, sum, third, div_res;
   logic [4:0]          sh;
   logic [PW-1:0]       pc4, br_pc;
   logic                mem_we;
   logic [AW-1:0]       mem_wa, mem_ra;
   logic [31:0]         mem_wd;
   logic                div_start;
   logic                div_res_done;

   // instruction fields
   assign op    = rsc_pkg::op_type'(ir_ff[31:27]);
   assign rdi   = ir_ff[25:22];
   assign rs1   = ir_ff[21:18];
   assign rs2   = ir_ff[17:14];
   always_comb begin
      case (ir_ff[17:16])
         2'd1:    imm = {16'd0, ir_ff[15:0]};
         2'd2:    imm = {ir_ff[15:0], 16'd0};
         default: imm = {{16{ir_ff[15]}}, ir_ff[15:0]};
      endcase
   end
   assign b     = ir_ff[26] ? imm : rs2v_ff;
   assign sh    = b[4:0];
   assign sum   = a_ff + b;
   assign third = rfb_q_ff;
   assign pc4   = pc_ff + PW'(4);
   assign br_pc = pc_ff + PW'({{3{ir_ff[26]}}, ir_ff[26:0], 2'b00});

   // register file, two registered read ports, valid bits give reset zero
   assign ra = rs1;
   assign rb = cmd.read_third ? ((op == rsc_pkg::OP_RET) ? rsc_pkg::LINK_REG : rdi) : rs2;

   always_ff @(posedge clock) begin
      if (reset) rf_vld_ff <= '0;
      else if (cmd.commit && req_ff.cmd && wr_ff) rf_vld_ff[rd_ff] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && req_ff.cmd && wr_ff) rf_mem[rd_ff] <= val_ff;
      rfa_q_ff <= rf_vld_ff[ra] ? rf_mem[ra] : '0;
      rfb_q_ff <= rf_vld_ff[rb] ? rf_mem[rb] : '0;
   end

   // word memory, one write and one registered read per cycle
   always_comb begin
      mem_we = 1'b0;
      mem_wa = rsc_pkg::word_index(sum);
      mem_wd = third;
      if (cmd.mem_clear) begin
         mem_we = 1'b1;
         mem_wa = clr_cnt_ff;
         mem_wd = '0;
      end else if (cmd.load_wr) begin
         mem_we = 1'b1;
         mem_wa = rsc_pkg::word_index(32'(req_ff.load_address));
         mem_wd = req_ff.load_word;
      end else if (cmd.exec && op == rsc_pkg::OP_ST) begin
         mem_we = 1'b1;
      end
      mem_ra = cmd.fetch ? pc_ff[PW-1:2] : rsc_pkg::word_index(sum);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_cnt_ff <= '0;
      else if (cmd.mem_clear) clr_cnt_ff <= clr_cnt_ff + AW'(1);
   end

   // divider
   assign div_start = cmd.exec && sts.is_div;
   rsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .want_rem (op == rsc_pkg::OP_MOD),
      .dividend (a_ff),
      .divisor  (b),
      .done     (div_res_done),
      .result   (div_res)
   );

   assign sts.clear_last = &clr_cnt_ff;
   assign sts.is_div     = (op == rsc_pkg::OP_DIV || op == rsc_pkg::OP_MOD) && (b != '0);
   assign sts.is_ld      = (op == rsc_pkg::OP_LD);
   assign sts.div_done   = div_res_done;

   // execute
   always_comb begin
      val_in  = '0;
      wr_in   = 1'b1;
      rd_in   = rdi;
      npc_in  = pc4;
      stat_in = rsc_pkg::STAT_OK;
      neq_in  = eq_ff;
      ngt_in  = gt_ff;
      case (op)
         rsc_pkg::OP_ADD: val_in = sum;
         rsc_pkg::OP_SUB: val_in = a_ff - b;
         rsc_pkg::OP_MUL: val_in = 32'(a_ff * b);
         rsc_pkg::OP_DIV, rsc_pkg::OP_MOD: begin
            if (b == '0) stat_in = rsc_pkg::STAT_DIV_ZERO;
         end
         rsc_pkg::OP_CMP: begin
            neq_in = (a_ff == b);
            ngt_in = ($signed(a_ff) > $signed(b));
            wr_in  = 1'b0;
         end
         rsc_pkg::OP_AND: val_in = a_ff & b;
         rsc_pkg::OP_OR:  val_in = a_ff | b;
         rsc_pkg::OP_NOT: val_in = ~b;
         rsc_pkg::OP_MOV: val_in = b;
         rsc_pkg::OP_LSL: val_in = a_ff << sh;
         rsc_pkg::OP_LSR: val_in = a_ff >> sh;
         rsc_pkg::OP_ASR: val_in = 32'($signed(a_ff) >>> sh);
         rsc_pkg::OP_NOP: wr_in = 1'b0;
         rsc_pkg::OP_LD:  val_in = '0;
         rsc_pkg::OP_ST:  wr_in = 1'b0;
         rsc_pkg::OP_BEQ: begin
            wr_in = 1'b0;
            if (eq_ff) npc_in = br_pc;
         end
         rsc_pkg::OP_BGT: begin
            wr_in = 1'b0;
            if (gt_ff) npc_in = br_pc;
         end
         rsc_pkg::OP_B: begin
            wr_in  = 1'b0;
            npc_in = br_pc;
         end
         rsc_pkg::OP_CALL: begin
            // return address is not wrapped, the last word links to 4096
            rd_in  = rsc_pkg::LINK_REG;
            val_in = 32'(pc_ff) + 32'd4;
            npc_in = br_pc;
         end
         rsc_pkg::OP_RET: begin
            wr_in  = 1'b0;
            npc_in = {third[PW-1:2], 2'b00};
         end
         default: begin
            wr_in   = 1'b0;
            stat_in = rsc_pkg::STAT_UNDEF;
         end
      endcase
      if (!wr_in) rd_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         eq_ff <= 1'b0;
         gt_ff <= 1'b0;
      end else if (cmd.commit && req_ff.cmd) begin
         pc_ff <= npc_ff;
         eq_ff <= neq_ff;
         gt_ff <= ngt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept)  req_ff <= req_payload;
      if (cmd.ir_load) ir_ff  <= mem_q_ff;
      if (cmd.ops_load) begin
         a_ff    <= rfa_q_ff;
         rs2v_ff <= rfb_q_ff;
      end
      if (cmd.exec) begin
         val_ff  <= val_in;
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         npc_ff  <= npc_in;
         stat_ff <= stat_in;
         neq_ff  <= neq_in;
         ngt_ff  <= ngt_in;
      end else if (div_res_done) begin
         val_ff <= div_res;
      end else if (cmd.mem_capture) begin
         val_ff <= mem_q_ff;
      end
      if (cmd.commit) begin
         if (req_ff.cmd) begin
            rsp_ff.exec_pc     <= rsc_pkg::OUT_PC_W'(pc_ff);
            rsp_ff.next_pc     <= rsc_pkg::OUT_PC_W'(npc_ff);
            rsp_ff.reg_written <= wr_ff;
            rsp_ff.dest_reg    <= 4'(rd_ff);
            rsp_ff.write_value <= wr_ff ? val_ff : '0;
            rsp_ff.flag_eq     <= neq_ff;
            rsp_ff.flag_gt     <= ngt_ff;
            rsp_ff.status      <= stat_ff;
         end else begin
            rsp_ff.exec_pc     <= rsc_pkg::OUT_PC_W'(pc_ff);
            rsp_ff.next_pc     <= rsc_pkg::OUT_PC_W'(pc_ff);
            rsp_ff.reg_written <= 1'b0;
            rsp_ff.dest_reg    <= '0;
            rsp_ff.write_value <= '0;
            rsp_ff.flag_eq     <= eq_ff;
            rsp_ff.flag_gt     <= gt_ff;
            rsp_ff.status      <= rsc_pkg::STAT_OK;
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== src/rsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsc_ctrl
// sequencer: memory clear, load, fetch, decode, operand read, execute, divide or memory wait, write-back
// ----------------------------------------------------------------------------
module rsc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_is_step,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsc_pkg::dp_sts_type sts,
   output rsc_pkg::dp_cmd_type cmd
);

   rsc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsc_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rsc_pkg::S_CLEAR: begin
            cmd.mem_clear = 1'b1;
            if (sts.clear_last) state_in = rsc_pkg::S_IDLE;
         end
         rsc_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) state_in = req_is_step ? rsc_pkg::S_FETCH : rsc_pkg::S_LOAD;
         end
         rsc_pkg::S_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = rsc_pkg::S_WB;
         end
         rsc_pkg::S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = rsc_pkg::S_DECODE;
         end
         rsc_pkg::S_DECODE: begin
            cmd.ir_load = 1'b1;
            state_in    = rsc_pkg::S_READ;
         end
         rsc_pkg::S_READ: state_in = rsc_pkg::S_OPER;
         rsc_pkg::S_OPER: begin
            cmd.ops_load   = 1'b1;
            cmd.read_third = 1'b1;
            state_in       = rsc_pkg::S_EXEC;
         end
         rsc_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.is_div)     state_in = rsc_pkg::S_DIV;
            else if (sts.is_ld) state_in = rsc_pkg::S_MEM;
            else                state_in = rsc_pkg::S_WB;
         end
         rsc_pkg::S_DIV: begin
            if (sts.div_done) state_in = rsc_pkg::S_WB;
         end
         rsc_pkg::S_MEM: begin
            cmd.mem_capture = 1'b1;
            state_in        = rsc_pkg::S_WB;
         end
         rsc_pkg::S_WB: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = rsc_pkg::S_IDLE;
            end
         end
         default: state_in = rsc_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/risc_instruction_step_core_unit.sv =====
// ----------------------------------------------------------------------------
// risc_instruction_step_core_unit
// 32-bit simplerisc core stepping one instruction per request beat
// ----------------------------------------------------------------------------
// After reset the core clears its 1024-word memory, one word a cycle, so
// req_ready stays low until the clear is done. A load beat (cmd 0) writes
// one memory word and then returns a result. A step beat (cmd 1) runs
// through fetch, decode, the read and oper register-read states and
// execute; ld adds a memory state, and div/mod with a nonzero divisor
// waits on the divider, which gives one quotient bit per cycle. Only one
// beat is in flight; the result register holds a finished beat while the
// next request is taken.
module risc_instruction_step_core_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rsc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsc_pkg::rsp_type rsp_payload
);

   // controller / datapath link
   rsc_pkg::dp_cmd_type dp_cmd;
   rsc_pkg::dp_sts_type dp_sts;

   rsc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_step (req_payload.cmd),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .sts         (dp_sts),
      .cmd         (dp_cmd)
   );

   rsc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (dp_cmd),
      .sts         (dp_sts),
      .rsp_payload (rsp_payload)
   );

   // a commit never overwrites a beat still waiting on the result side
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("commit over pending result");

   // one item at a time
   a_single: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while busy");

   // divide by zero writes zero
   a_divzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == rsc_pkg::STAT_DIV_ZERO) |->
      (rsp_payload.reg_written && rsp_payload.write_value == '0))
      else $error("divide by zero result not zero");

   // no write means no destination
   a_nowrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.reg_written) |->
      (rsp_payload.dest_reg == '0 && rsp_payload.write_value == '0))
      else $error("write fields set without a write");

endmodule

// ===== bench/rsc_step_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_step_checker
// watches both channels of the step core, predicts each result beat from its
// own copy of registers, memory, pc and flags, and compares it field by field
// ----------------------------------------------------------------------------
module rsc_step_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rsc_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsc_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               pending_count,
   output logic [11:0]      pc_hint
);

   logic [31:0]      regs [rsc_pkg::NUM_REGS];
   logic [31:0]      mem [rsc_pkg::MEM_WORDS];
   logic [31:0]      cur_pc;
   logic             eq_q;
   logic             gt_q;
   rsc_pkg::rsp_type step_results [$];
   int               fails;

   // magnitude divide, quotient toward zero, remainder follows dividend
   function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b,
                                        input bit want_rem);
      logic [31:0] ma;
      logic [31:0] mb;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      if (want_rem) return a[31] ? -(ma % mb) : ma % mb;
      return (a[31] ^ b[31]) ? -(ma / mb) : ma / mb;
   endfunction

   task automatic run_beat(input rsc_pkg::req_type r);
      rsc_pkg::rsp_type    e;
      logic [31:0]         w, a, b, imm, off, npc, val;
      logic [4:0]          op;
      logic [3:0]          rdi;
      logic                wr;
      rsc_pkg::status_type st;
      e = '0;
      e.exec_pc = cur_pc[11:0];
      e.next_pc = cur_pc[11:0];
      if (!r.cmd) begin
         mem[r.load_address[11:2]] = r.load_word;
      end else begin
         w   = mem[cur_pc[11:2]];
         op  = w[31:27];
         rdi = w[25:22];
         a   = regs[w[21:18]];
         case (w[17:16])
            2'd1: imm = {16'h0, w[15:0]};
            2'd2: imm = {w[15:0], 16'h0};
            default: imm = {{16{w[15]}}, w[15:0]};
         endcase
         b   = w[26] ? imm : regs[w[17:14]];
         off = {{5{w[26]}}, w[26:0]} << 2;
         npc = cur_pc + 32'd4;
         wr  = 1'b1;
         val = '0;
         st  = rsc_pkg::STAT_OK;
         case (rsc_pkg::op_type'(op))
            rsc_pkg::OP_ADD: val = a + b;
            rsc_pkg::OP_SUB: val = a - b;
            rsc_pkg::OP_MUL: val = a * b;
            rsc_pkg::OP_DIV, rsc_pkg::OP_MOD: begin
               if (b == 0) st = rsc_pkg::STAT_DIV_ZERO;
               else val = sdiv(a, b, op == rsc_pkg::OP_MOD);
            end
            rsc_pkg::OP_CMP: begin
               eq_q = (a == b);
               gt_q = ($signed(a) > $signed(b));
               wr   = 1'b0;
            end
            rsc_pkg::OP_AND: val = a & b;
            rsc_pkg::OP_OR:  val = a | b;
            rsc_pkg::OP_NOT: val = ~b;
            rsc_pkg::OP_MOV: val = b;
            rsc_pkg::OP_LSL: val = a << b[4:0];
            rsc_pkg::OP_LSR: val = a >> b[4:0];
            rsc_pkg::OP_ASR: val = $signed(a) >>> b[4:0];
            rsc_pkg::OP_NOP: wr = 1'b0;
            rsc_pkg::OP_LD:  val = mem[(a + b) >> 2 & 32'h3ff];
            rsc_pkg::OP_ST: begin
               mem[((a + b) >> 2) & 32'h3ff] = regs[rdi];
               wr = 1'b0;
            end
            rsc_pkg::OP_BEQ: begin
               if (eq_q) npc = cur_pc + off;
               wr = 1'b0;
            end
            rsc_pkg::OP_BGT: begin
               if (gt_q) npc = cur_pc + off;
               wr = 1'b0;
            end
            rsc_pkg::OP_B: begin
               npc = cur_pc + off;
               wr  = 1'b0;
            end
            rsc_pkg::OP_CALL: begin
               rdi = rsc_pkg::LINK_REG;
               val = cur_pc + 32'd4;
               npc = cur_pc + off;
            end
            rsc_pkg::OP_RET: begin
               npc = regs[rsc_pkg::LINK_REG];
               wr  = 1'b0;
            end
            default: begin
               wr = 1'b0;
               st = rsc_pkg::STAT_UNDEF;
            end
         endcase
         if (wr) regs[rdi] = val;
         npc    = {20'h0, npc[11:2], 2'b00};
         cur_pc = npc;
         e.next_pc     = npc[11:0];
         e.reg_written = wr;
         e.dest_reg    = wr ? rdi : 4'd0;
         e.write_value = wr ? val : 32'd0;
         e.status      = st;
      end
      e.flag_eq = eq_q;
      e.flag_gt = gt_q;
      step_results.push_back(e);
   endtask

   task automatic cmp_field(input string name, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      rsc_pkg::rsp_type e;
      if (reset) begin
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         cur_pc = '0;
         eq_q   = 1'b0;
         gt_q   = 1'b0;
         fails  = 0;
         step_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (step_results.size() == 0) begin
               $error("result beat with no expectation waiting");
               fails++;
            end else begin
               e = step_results.pop_front();
               cmp_field("exec_pc", 32'(e.exec_pc), 32'(rsp_payload.exec_pc));
               cmp_field("next_pc", 32'(e.next_pc), 32'(rsp_payload.next_pc));
               cmp_field("reg_written", 32'(e.reg_written),
                         32'(rsp_payload.reg_written));
               cmp_field("dest_reg", 32'(e.dest_reg), 32'(rsp_payload.dest_reg));
               cmp_field("write_value", e.write_value, rsp_payload.write_value);
               cmp_field("flag_eq", 32'(e.flag_eq), 32'(rsp_payload.flag_eq));
               cmp_field("flag_gt", 32'(e.flag_gt), 32'(rsp_payload.flag_gt));
               cmp_field("status", 32'(e.status), 32'(rsp_payload.status));
            end
         end
         if (req_valid && req_ready) run_beat(req_payload);
      end
      fail_count    <= fails;
      pending_count <= step_results.size();
      pc_hint       <= cur_pc[11:0];
   end

endmodule

// ===== bench/tb_risc_instruction_step_core_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_risc_instruction_step_core_unit
// drives load and step beats into the core: a directed program for the
// corner cases, then random programs written just ahead of the pc and
// stepped, with random gaps on both channels and one long result stall
// ----------------------------------------------------------------------------
module tb_risc_instruction_step_core_unit;

   localparam int ITEM_TARGET = 1150;
   localparam int IDLE_LIMIT  = 5000;   // covers the memory clear and the long stall

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   rsc_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   rsc_pkg::rsp_type rsp_payload;
   int               fail_count;
   int               pending_count;
   logic [11:0]      pc_hint;
   int               items_sent;
   int               idle_cycles;
   bit               quiet;

   risc_instruction_step_core_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   rsc_step_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .pc_hint       (pc_hint)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // instruction encoders: register form, immediate form, branch form
   function automatic logic [31:0] enc_r(input rsc_pkg::op_type op, input logic [3:0] rd,
                                         input logic [3:0] rs1, input logic [3:0] rs2);
      return {op, 1'b0, rd, rs1, rs2, 14'h0};
   endfunction

   function automatic logic [31:0] enc_i(input rsc_pkg::op_type op, input logic [3:0] rd,
                                         input logic [3:0] rs1, input logic [1:0] md,
                                         input logic [15:0] imm);
      return {op, 1'b1, rd, rs1, md, imm};
   endfunction

   function automatic logic [31:0] enc_br(input rsc_pkg::op_type op, input logic [26:0] off);
      return {op, off};
   endfunction

   // random instruction, mostly defined opcodes, branches mostly short
   function automatic logic [31:0] rand_instr();
      logic [31:0] w;
      logic [4:0]  op;
      w  = $urandom;
      op = ($urandom_range(0, 99) < 88) ? 5'($urandom_range(0, 20))
                                        : 5'($urandom_range(0, 31));
      w[31:27] = op;
      if (op >= rsc_pkg::OP_BEQ && op <= rsc_pkg::OP_CALL && $urandom_range(0, 9) < 8)
         w[26:0] = 27'($signed($urandom_range(0, 16)) - 8);
      return w;
   endfunction

   // one request beat; at_pc places a load relative to the predicted pc,
   // which needs an idle gap before the beat so the prediction is settled
   task automatic send(input logic cmd, input logic [11:0] addr,
                       input logic [31:0] data, input bit at_pc);
      int               gap;
      rsc_pkg::req_type p;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (at_pc && gap == 0) gap = 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      p.cmd          = cmd;
      p.load_address = at_pc ? pc_hint + addr : addr;
      p.load_word    = data;
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // write an instruction at the pc and execute it
   task automatic exec_instr(input logic [31:0] w);
      send(1'b0, 12'h0, w, 1'b1);
      send(1'b1, 12'($urandom), $urandom, 1'b0);
   endtask

   // result side: random ready gaps, one long hold-off to back up the core
   initial begin
      int gap;
      int beats;
      rsp_ready <= 1'b0;
      beats = 0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 13);
         if (beats == 200) gap = 400;
         else if (quiet) gap = 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats++;
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL risc_instruction_step_core_unit");
            $finish;
         end
      end
   end

   initial begin
      int k;
      int n;
      req_valid   <= 1'b0;
      req_payload <= '0;
      reset       <= 1'b1;
      items_sent  = 0;
      quiet       = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: top of the address range and a full word, then corner cases
      send(1'b0, 12'hfff, 32'hffff_ffff, 1'b0);
      exec_instr(enc_i(rsc_pkg::OP_MOV, 4'd1, 4'd0, 2'd2, 16'h8000));   // most negative
      exec_instr(enc_i(rsc_pkg::OP_MOV, 4'd2, 4'd0, 2'd0, 16'hffff));   // minus one
      exec_instr(enc_r(rsc_pkg::OP_DIV, 4'd3, 4'd1, 4'd2));             // overflow wraps
      exec_instr(enc_r(rsc_pkg::OP_MOD, 4'd4, 4'd1, 4'd2));             // overflow rem 0
      exec_instr(enc_i(rsc_pkg::OP_DIV, 4'd5, 4'd1, 2'd0, 16'h0));      // divide by zero
      exec_instr(enc_i(rsc_pkg::OP_MOD, 4'd5, 4'd2, 2'd3, 16'hfff9));   // negative dividend
      exec_instr(enc_r(rsc_pkg::OP_CMP, 4'd0, 4'd2, 4'd1));             // gt set
      exec_instr(enc_i(rsc_pkg::OP_ASR, 4'd6, 4'd1, 2'd1, 16'd33));     // shift uses 5 bits
      exec_instr(enc_i(rsc_pkg::OP_ST, 4'd1, 4'd0, 2'd0, 16'hfffc));    // wraps to last word
      exec_instr(enc_i(rsc_pkg::OP_LD, 4'd7, 4'd0, 2'd0, 16'hfffc));
      exec_instr(enc_br(rsc_pkg::OP_BGT, 27'h7ff_fffe));                // taken, backward
      exec_instr(enc_br(rsc_pkg::OP_CALL, 27'd3));
      exec_instr({5'd31, 27'h7ff_ffff});                                // undefined opcode
      exec_instr(enc_r(rsc_pkg::OP_RET, 4'd0, 4'd0, 4'd0));

      // random programs written just ahead of the pc, with some noise
      while (items_sent < ITEM_TARGET) begin
         quiet = ($urandom_range(0, 9) < 2);
         k = $urandom_range(0, 99);
         if (k < 75) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) send(1'b0, 12'(4 * i), rand_instr(), 1'b1);
            for (int i = 0; i < n; i++) send(1'b1, 12'($urandom), $urandom, 1'b0);
         end else if (k < 90) begin
            send(1'b0, 12'($urandom), $urandom, 1'b0);
         end else begin
            send(1'b1, 12'($urandom), $urandom, 1'b0);
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS risc_instruction_step_core_unit");
      else
         $display("FAIL risc_instruction_step_core_unit");
      $finish;
   end

endmodule
